[sv/bsrl_pkg.sv]
// Shared widths, types and codes for the box versus shell refinement classifier.
package bsrl_pkg;

	localparam int COORD_W = 24;              // signed Q12.12 coordinate
	localparam int DIFF_W  = COORD_W + 1;     // coordinate difference / magnitude
	localparam int RAD_W   = 23;              // unsigned Q11.12 radius
	localparam int LVL_W   = 5;               // signed refinement level
	localparam int BLK_W   = 4;               // unsigned block level
	localparam int SIDX_W  = 3;               // shell index field
	localparam int CNT_W   = 5;               // shell count, wide enough for the table depth
	localparam int SQ_W    = 2 * DIFF_W;      // squared distance and sums of three squares

	// register indexes
	localparam logic [2:0] REG_CENTER_X      = 3'd0;
	localparam logic [2:0] REG_CENTER_Y      = 3'd1;
	localparam logic [2:0] REG_CENTER_Z      = 3'd2;
	localparam logic [2:0] REG_FILLED_RADIUS = 3'd3;
	localparam logic [2:0] REG_FILLED_LEVEL  = 3'd4;
	localparam logic [2:0] REG_SHELL_COUNT   = 3'd5;

	// item opcodes
	localparam logic OP_LOAD     = 1'b0;
	localparam logic OP_CLASSIFY = 1'b1;

	// action codes
	localparam logic signed [1:0] ACT_COARSEN = -2'sd1;
	localparam logic signed [1:0] ACT_KEEP    = 2'sd0;
	localparam logic signed [1:0] ACT_REFINE  = 2'sd1;

	// level when no region touches the box
	localparam logic signed [LVL_W-1:0] LVL_NONE = LVL_W'(-1);

	// Table write request, one load item
	typedef struct packed {
		logic                    en;
		logic [SIDX_W-1:0]       idx;
		logic [RAD_W-1:0]        inner;
		logic [RAD_W-1:0]        outer;
		logic signed [LVL_W-1:0] level;
	} shell_wr_t;

	// One shell table entry
	typedef struct packed {
		logic [RAD_W-1:0]        inner;
		logic [RAD_W-1:0]        outer;
		logic signed [LVL_W-1:0] level;
	} shell_entry_t;

endpackage

[sv/bsrl_shell_tab.sv]
// Shell table: inner radius, outer radius and level per entry, loaded by load items.
module bsrl_shell_tab import bsrl_pkg::*; #(
	parameter int MAX_SHELLS = 8,
	parameter int IW = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1
) (
	input  logic         clk,
	input  shell_wr_t    wr,
	input  logic [IW-1:0] rd_idx,
	output shell_entry_t rd_entry
);

	localparam int XW = (IW > SIDX_W) ? IW : SIDX_W;

	shell_entry_t  tab_q [MAX_SHELLS];
	logic [XW-1:0] wr_idx_x;
	logic          wr_in_range;

	// Loads beyond the table depth are dropped
	assign wr_idx_x    = XW'(wr.idx);
	assign wr_in_range = (CNT_W'(wr.idx) < CNT_W'(MAX_SHELLS));

	always_ff @(posedge clk) begin
		if (wr.en && wr_in_range) begin
			tab_q[wr_idx_x[IW-1:0]] <= '{inner: wr.inner, outer: wr.outer, level: wr.level};
		end
	end

	assign rd_entry = tab_q[rd_idx];

endmodule

[sv/box_shell_refinement_level.sv]
// Top level: box versus filled ball and spherical shells, answers coarsen, keep or refine.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------------
//  in      | in_valid / in_ready    | op, shell_index, shell_inner, shell_outer,
//          |                        | shell_level, block_level, x/y/z_min, x/y/z_max
//  out     | out_valid / out_ready  | refine_action, wanted_level
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// A load item gives no result and leaves the block in IDLE, so in_ready stays high.
// A classify item runs 7 + 2*N squarings through one 25x25 squaring unit (N = shell count,
// clamped to MAX_SHELLS), then drains through the pipeline and writes the output register;
// in_ready stays low from acceptance until then, so classifies do not overlap.
// A finished item waits in FIN only while the output register still holds an unread result.
// cfg_ready is always high; reset loads the configuration defaults, not the shell table.
module box_shell_refinement_level import bsrl_pkg::*; #(
	parameter int MAX_SHELLS = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// item input
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      op,
	input  logic [SIDX_W-1:0]         shell_index,
	input  logic [RAD_W-1:0]          shell_inner,
	input  logic [RAD_W-1:0]          shell_outer,
	input  logic signed [LVL_W-1:0]   shell_level,
	input  logic [BLK_W-1:0]          block_level,
	input  logic signed [COORD_W-1:0] x_min,
	input  logic signed [COORD_W-1:0] x_max,
	input  logic signed [COORD_W-1:0] y_min,
	input  logic signed [COORD_W-1:0] y_max,
	input  logic signed [COORD_W-1:0] z_min,
	input  logic signed [COORD_W-1:0] z_max,
	// result output
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [1:0]         refine_action,
	output logic signed [LVL_W-1:0]   wanted_level,
	// configuration writes
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [2:0]                cfg_index,
	input  logic [COORD_W-1:0]        cfg_data
);

	localparam int IW = (MAX_SHELLS > 1) ? $clog2(MAX_SHELLS) : 1;

	// squaring step kinds
	localparam logic [2:0] K_NEAR  = 3'd0;
	localparam logic [2:0] K_FAR   = 3'd1;
	localparam logic [2:0] K_FILL  = 3'd2;
	localparam logic [2:0] K_INNER = 3'd3;
	localparam logic [2:0] K_OUTER = 3'd4;

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;
	localparam logic [1:0] ST_FIN  = 2'd3;

	// configuration registers
	logic signed [COORD_W-1:0] center_x_q, center_y_q, center_z_q;
	logic [RAD_W-1:0]          fill_rad_q;
	logic signed [LVL_W-1:0]   fill_lvl_q;
	logic [3:0]                sh_count_q;

	// captured classify item
	logic [BLK_W-1:0]          blk_lvl_q;
	logic signed [COORD_W-1:0] lo_q [3];
	logic signed [COORD_W-1:0] hi_q [3];

	// sequencer
	logic [1:0]    state_q;
	logic [2:0]    kind_q;
	logic [1:0]    axis_q;
	logic [IW-1:0] sh_q;
	logic [CNT_W-1:0] n_shells;
	logic          issue, issue_last;

	// pipeline
	logic              v_s1, v_s2, last_s1, last_s2;
	logic [2:0]        kind_s1, kind_s2;
	logic [DIFF_W-1:0] mag_s1;
	logic [SQ_W-1:0]   prod_s2;
	logic signed [LVL_W-1:0] lvl_s1, lvl_s2;

	// accumulators
	logic [SQ_W-1:0]         min2_q, max2_q;
	logic                    hit_in_q;
	logic signed [LVL_W-1:0] desired_q;

	// output register
	logic                    out_valid_q;
	logic [1:0]              act_q;
	logic signed [LVL_W-1:0] dlvl_q;

	logic         in_acc;
	shell_wr_t    sh_wr;
	shell_entry_t sh_rd;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			center_z_q <= '0;
			fill_rad_q <= RAD_W'(8192);
			fill_lvl_q <= LVL_W'(1);
			sh_count_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_CENTER_X:      center_x_q <= cfg_data;
				REG_CENTER_Y:      center_y_q <= cfg_data;
				REG_CENTER_Z:      center_z_q <= cfg_data;
				REG_FILLED_RADIUS: fill_rad_q <= cfg_data[RAD_W-1:0];
				REG_FILLED_LEVEL:  fill_lvl_q <= cfg_data[LVL_W-1:0];
				REG_SHELL_COUNT:   sh_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// shell table
	assign sh_wr = '{en: in_acc && (op == OP_LOAD), idx: shell_index,
		inner: shell_inner, outer: shell_outer, level: shell_level};

	bsrl_shell_tab #(.MAX_SHELLS(MAX_SHELLS), .IW(IW)) u_tab (
		.clk      (clk),
		.wr       (sh_wr),
		.rd_idx   (sh_q),
		.rd_entry (sh_rd)
	);

	// capture classify box
	always_ff @(posedge clk) begin
		if (in_acc && (op == OP_CLASSIFY)) begin
			blk_lvl_q <= block_level;
			lo_q[0]   <= x_min;
			hi_q[0]   <= x_max;
			lo_q[1]   <= y_min;
			hi_q[1]   <= y_max;
			lo_q[2]   <= z_min;
			hi_q[2]   <= z_max;
		end
	end

	// shells in use, clamped to the table depth
	assign n_shells = (CNT_W'(sh_count_q) > CNT_W'(MAX_SHELLS)) ?
		CNT_W'(MAX_SHELLS) : CNT_W'(sh_count_q);

	assign issue      = (state_q == ST_RUN);
	assign issue_last = ((kind_q == K_FILL) && (n_shells == '0)) ||
		((kind_q == K_OUTER) && (CNT_W'(sh_q) == n_shells - CNT_W'(1)));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= K_NEAR;
			axis_q  <= '0;
			sh_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (op == OP_CLASSIFY)) begin
						state_q <= ST_RUN;
						kind_q  <= K_NEAR;
						axis_q  <= '0;
						sh_q    <= '0;
					end
				end
				ST_RUN: begin
					if (issue_last) begin
						state_q <= ST_WAIT;
					end else begin
						case (kind_q)
							K_NEAR: begin
								if (axis_q == 2'd2) begin
									kind_q <= K_FAR;
									axis_q <= '0;
								end else begin
									axis_q <= axis_q + 2'd1;
								end
							end
							K_FAR: begin
								if (axis_q == 2'd2) begin
									kind_q <= K_FILL;
								end else begin
									axis_q <= axis_q + 2'd1;
								end
							end
							K_FILL:  kind_q <= K_INNER;
							K_INNER: kind_q <= K_OUTER;
							K_OUTER: begin
								kind_q <= K_INNER;
								sh_q   <= sh_q + IW'(1);
							end
							default: kind_q <= K_NEAR;
						endcase
					end
				end
				ST_WAIT: begin
					if (v_s2 && last_s2) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// operand selection: per-axis offsets, radii
	logic signed [COORD_W-1:0] cen, lo, hi;
	logic signed [DIFF_W-1:0]  d_lo, d_hi;
	logic [DIFF_W-1:0]         a_lo, a_hi, near_mag, far_mag, mag;

	always_comb begin
		case (axis_q)
			2'd0:    cen = center_x_q;
			2'd1:    cen = center_y_q;
			default: cen = center_z_q;
		endcase
		lo = (axis_q == 2'd3) ? lo_q[0] : lo_q[axis_q];
		hi = (axis_q == 2'd3) ? hi_q[0] : hi_q[axis_q];
		d_lo = DIFF_W'(lo) - DIFF_W'(cen);
		d_hi = DIFF_W'(cen) - DIFF_W'(hi);
		a_lo = d_lo[DIFF_W-1] ? DIFF_W'(-d_lo) : DIFF_W'(d_lo);
		a_hi = d_hi[DIFF_W-1] ? DIFF_W'(-d_hi) : DIFF_W'(d_hi);
		// nearest: below the box, above it, or inside
		if (!d_lo[DIFF_W-1] && (d_lo != '0)) begin
			near_mag = DIFF_W'(d_lo);
		end else if (!d_hi[DIFF_W-1] && (d_hi != '0)) begin
			near_mag = DIFF_W'(d_hi);
		end else begin
			near_mag = '0;
		end
		far_mag = (a_lo > a_hi) ? a_lo : a_hi;
		case (kind_q)
			K_NEAR:  mag = near_mag;
			K_FAR:   mag = far_mag;
			K_FILL:  mag = DIFF_W'(fill_rad_q);
			K_INNER: mag = DIFF_W'(sh_rd.inner);
			K_OUTER: mag = DIFF_W'(sh_rd.outer);
			default: mag = '0;
		endcase
	end

	// pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
		end
	end

	// stage 1: operand register; stage 2: shared squaring unit
	always_ff @(posedge clk) begin
		kind_s1 <= kind_q;
		last_s1 <= issue_last;
		mag_s1  <= mag;
		lvl_s1  <= sh_rd.level;
		kind_s2 <= kind_s1;
		last_s2 <= last_s1;
		prod_s2 <= SQ_W'(mag_s1) * SQ_W'(mag_s1);
		lvl_s2  <= lvl_s1;
	end

	// accumulate squared distances, test regions, keep the largest level
	always_ff @(posedge clk) begin
		if (in_acc && (op == OP_CLASSIFY)) begin
			min2_q    <= '0;
			max2_q    <= '0;
			hit_in_q  <= 1'b0;
			desired_q <= LVL_NONE;
		end else if (v_s2) begin
			case (kind_s2)
				K_NEAR: min2_q <= min2_q + prod_s2;
				K_FAR:  max2_q <= max2_q + prod_s2;
				K_FILL: begin
					if ((min2_q <= prod_s2) && (fill_lvl_q > desired_q)) begin
						desired_q <= fill_lvl_q;
					end
				end
				K_INNER: hit_in_q <= (max2_q >= prod_s2);
				K_OUTER: begin
					if (hit_in_q && (min2_q <= prod_s2) && (lvl_s2 > desired_q)) begin
						desired_q <= lvl_s2;
					end
				end
				default: ;
			endcase
		end
	end

	// output register
	logic [1:0] act;
	always_comb begin
		if (desired_q[LVL_W-1]) begin
			act = ACT_COARSEN;
		end else if (LVL_W'(blk_lvl_q) < desired_q[LVL_W-1:0]) begin
			act = ACT_REFINE;
		end else if (LVL_W'(blk_lvl_q) > desired_q[LVL_W-1:0]) begin
			act = ACT_COARSEN;
		end else begin
			act = ACT_KEEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_FIN) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_FIN) && (!out_valid_q || out_ready)) begin
			act_q  <= act;
			dlvl_q <= desired_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign refine_action = act_q;
	assign wanted_level  = dlvl_q;

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench for the box versus sphere-and-shell refinement classifier.
module tb_top import bsrl_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	// Indexes with no register behind them
	localparam logic [2:0] REG_UNMAPPED_6    = 3'd6;
	localparam logic [2:0] REG_UNMAPPED_7    = 3'd7;

	localparam int     TABLE_DEPTH   = 8;
	localparam longint COORD_MIN     = -(longint'(1) << 23);
	localparam longint COORD_MAX     = (longint'(1) << 23) - 1;
	localparam longint RAD_MAX       = (longint'(1) << 23) - 1;
	localparam int     SETTLE_CYCLES = 40;
	localparam int     QUIET_LIMIT   = 2000;

	typedef struct packed {
		logic                      op;
		logic [SIDX_W-1:0]         sidx;
		logic [RAD_W-1:0]          inner;
		logic [RAD_W-1:0]          outer;
		logic signed [LVL_W-1:0]   slvl;
		logic [BLK_W-1:0]          blvl;
		logic signed [COORD_W-1:0] xl;
		logic signed [COORD_W-1:0] xh;
		logic signed [COORD_W-1:0] yl;
		logic signed [COORD_W-1:0] yh;
		logic signed [COORD_W-1:0] zl;
		logic signed [COORD_W-1:0] zh;
	} mesh_item_t;

	localparam int ITEM_W = $bits(mesh_item_t);

	typedef struct packed {
		logic signed [1:0]       action;
		logic signed [LVL_W-1:0] level;
	} verdict_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic op;
	logic [SIDX_W-1:0] shell_index;
	logic [RAD_W-1:0] shell_inner;
	logic [RAD_W-1:0] shell_outer;
	logic signed [LVL_W-1:0] shell_level;
	logic [BLK_W-1:0] block_level;
	logic signed [COORD_W-1:0] x_min, x_max, y_min, y_max, z_min, z_max;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [1:0] refine_action;
	logic signed [LVL_W-1:0] wanted_level;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;

	box_shell_refinement_level dut (.*);

	// Predictor copy of configuration and shell table
	logic signed [COORD_W-1:0] ctr_x = '0, ctr_y = '0, ctr_z = '0;
	logic [RAD_W-1:0] filled_rad = RAD_W'(8192);
	logic signed [LVL_W-1:0] filled_lvl = LVL_W'(1);
	logic [3:0] shell_cnt = '0;
	shell_entry_t shell_tab [TABLE_DEPTH];

	verdict_t expected_verdicts[$];
	int fail_count = 0;
	int n_classified = 0;
	int n_loads = 0;
	int n_writes = 0;
	int n_settings = 0;
	int gap_odds = 0;      // sender gap chance 1 in gap_odds, 0 = never
	int stall_odds = 0;    // receiver stall chance, same scheme
	int rx_hold = 0;
	int quiet_cycles = 0;

	// 12 ns clock
	always begin
		#6ns clk = 1'b1;
		#6ns clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------
	function automatic longint near_sq(longint c, longint lo, longint hi);
		longint d;
		d = 0;
		if (c < lo)
			d = lo - c;
		else if (c > hi)
			d = c - hi;
		return d * d;
	endfunction

	function automatic longint far_sq(longint c, longint lo, longint hi);
		longint a, b;
		a = (lo - c) * (lo - c);
		b = (hi - c) * (hi - c);
		return (a > b) ? a : b;
	endfunction

	function automatic verdict_t classify_box(mesh_item_t it);
		longint near2, far2, ri, ro;
		int want, lvl, n, k;
		verdict_t v;
		near2 = near_sq(ctr_x, $signed(it.xl), $signed(it.xh))
			+ near_sq(ctr_y, $signed(it.yl), $signed(it.yh))
			+ near_sq(ctr_z, $signed(it.zl), $signed(it.zh));
		far2 = far_sq(ctr_x, $signed(it.xl), $signed(it.xh))
			+ far_sq(ctr_y, $signed(it.yl), $signed(it.yh))
			+ far_sq(ctr_z, $signed(it.zl), $signed(it.zh));
		want = LVL_NONE;
		ri = longint'(filled_rad);
		if (near2 <= ri * ri && int'(filled_lvl) > want)
			want = int'(filled_lvl);
		// counts above the table depth are clamped
		n = (shell_cnt > TABLE_DEPTH) ? TABLE_DEPTH : int'(shell_cnt);
		for (k = 0; k < n; k++) begin
			ri = longint'(shell_tab[k].inner);
			ro = longint'(shell_tab[k].outer);
			if (far2 >= ri * ri && near2 <= ro * ro && int'($signed(shell_tab[k].level)) > want)
				want = int'($signed(shell_tab[k].level));
		end
		lvl = int'(it.blvl);
		if (want < 0)
			v.action = ACT_COARSEN;
		else if (lvl < want)
			v.action = ACT_REFINE;
		else if (lvl > want)
			v.action = ACT_COARSEN;
		else
			v.action = ACT_KEEP;
		v.level = want[LVL_W-1:0];
		return v;
	endfunction

	// ---------------------------------------------------------------
	// Item builders
	// ---------------------------------------------------------------
	function automatic logic [COORD_W-1:0] to_coord(longint v);
		if (v < COORD_MIN)
			v = COORD_MIN;
		if (v > COORD_MAX)
			v = COORD_MAX;
		return v[COORD_W-1:0];
	endfunction

	function automatic logic [RAD_W-1:0] to_radius(longint v);
		if (v > RAD_MAX)
			v = RAD_MAX;
		return v[RAD_W-1:0];
	endfunction

	function automatic mesh_item_t box_item(int lvl, longint xl, longint xh, longint yl,
			longint yh, longint zl, longint zh);
		mesh_item_t it;
		it = '0;
		it.op = OP_CLASSIFY;
		it.blvl = lvl[BLK_W-1:0];
		it.xl = to_coord(xl);
		it.xh = to_coord(xh);
		it.yl = to_coord(yl);
		it.yh = to_coord(yh);
		it.zl = to_coord(zl);
		it.zh = to_coord(zh);
		return it;
	endfunction

	function automatic mesh_item_t shell_item(int idx, longint inner, longint outer, int lvl);
		mesh_item_t it;
		it = '0;
		it.op = OP_LOAD;
		it.sidx = idx[SIDX_W-1:0];
		it.inner = to_radius(inner);
		it.outer = to_radius(outer);
		it.slvl = lvl[LVL_W-1:0];
		return it;
	endfunction

	// One box edge pair whose midpoint lies within span of the center coordinate
	function automatic void place_axis(input longint c, input int span,
			output logic [COORD_W-1:0] lo, output logic [COORD_W-1:0] hi);
		longint mid, half;
		mid = c + longint'($urandom_range(0, 2 * span)) - span;
		half = longint'($urandom_range(0, span));
		lo = to_coord(mid - half);
		hi = to_coord(mid + half);
	endfunction

	function automatic mesh_item_t make_box();
		mesh_item_t it;
		logic [COORD_W-1:0] t;
		int span;
		it = mesh_item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom}));
		it.op = OP_CLASSIFY;
		span = 1 << $urandom_range(6, 21);
		place_axis(ctr_x, span, it.xl, it.xh);
		place_axis(ctr_y, span, it.yl, it.yh);
		place_axis(ctr_z, span, it.zl, it.zh);
		case ($urandom_range(0, 9))
			0: begin
				// anywhere in the coordinate range
				it.xl = COORD_W'($urandom);
				it.xh = COORD_W'($urandom);
				it.yl = COORD_W'($urandom);
				it.yh = COORD_W'($urandom);
				it.zl = COORD_W'($urandom);
				it.zh = COORD_W'($urandom);
			end
			1: begin
				// inverted box on one axis
				t = it.yl;
				it.yl = it.yh;
				it.yh = t;
			end
			default: ;
		endcase
		return it;
	endfunction

	function automatic mesh_item_t make_shell();
		mesh_item_t it;
		logic [RAD_W-1:0] t;
		longint inner;
		int span;
		it = mesh_item_t'(ITEM_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom}));
		it.op = OP_LOAD;
		span = 1 << $urandom_range(6, 21);
		inner = longint'($urandom_range(0, 2 * span));
		it.inner = to_radius(inner);
		it.outer = to_radius(inner + longint'($urandom_range(0, 2 * span)));
		case ($urandom_range(0, 9))
			0: begin
				it.inner = RAD_W'($urandom);
				it.outer = RAD_W'($urandom);
			end
			1: begin
				// outer below inner
				t = it.inner;
				it.inner = it.outer;
				it.outer = t;
			end
			default: ;
		endcase
		if ($urandom_range(0, 15) != 0)
			it.slvl = LVL_W'($urandom_range(0, 16) - 1);
		return it;
	endfunction

	// ---------------------------------------------------------------
	// Channel drivers
	// ---------------------------------------------------------------
	task automatic send_item(input mesh_item_t it);
		if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= it.op;
		shell_index <= it.sidx;
		shell_inner <= it.inner;
		shell_outer <= it.outer;
		shell_level <= it.slvl;
		block_level <= it.blvl;
		x_min <= it.xl;
		x_max <= it.xh;
		y_min <= it.yl;
		y_max <= it.yh;
		z_min <= it.zl;
		z_max <= it.zh;
		do @(posedge clk); while (!in_ready);
		if (it.op == OP_CLASSIFY) begin
			expected_verdicts.push_back(classify_box(it));
		end else begin
			shell_tab[it.sidx] = '{inner: it.inner, outer: it.outer, level: it.slvl};
			n_loads++;
		end
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [COORD_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_CENTER_X:      ctr_x = data;
			REG_CENTER_Y:      ctr_y = data;
			REG_CENTER_Z:      ctr_z = data;
			REG_FILLED_RADIUS: filled_rad = data[RAD_W-1:0];
			REG_FILLED_LEVEL:  filled_lvl = data[LVL_W-1:0];
			REG_SHELL_COUNT:   shell_cnt = data[3:0];
			default: ;
		endcase
		n_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Hold the sender until every result is back, then let the block go quiet
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_verdicts.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Receiver with random stall bursts
	always @(posedge clk) begin
		if (rx_hold != 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else begin
			out_ready <= 1'b1;
			if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
				rx_hold = $urandom_range(1, 9);
		end
	end

	// Result checker
	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				$error("result with no classify item pending: refine_action %0d wanted_level %0d",
					refine_action, wanted_level);
				fail_count++;
			end else begin
				want = expected_verdicts.pop_front();
				n_classified++;
				if (refine_action !== want.action) begin
					$error("refine_action: expected %0d, actual %0d", want.action, refine_action);
					fail_count++;
				end
				if (wanted_level !== want.level) begin
					$error("wanted_level: expected %0d, actual %0d", want.level, wanted_level);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Stalled for %0d cycles with %0d results outstanding",
					quiet_cycles, expected_verdicts.size());
				$display("FAILURE");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// Reset configuration: unit-ish ball of radius 2.0 at the origin, level 1
	task automatic test_reset_defaults();
		send_item(box_item(0, -4096, 4096, -4096, 4096, -4096, 4096));
		send_item(box_item(1, -4096, 4096, -4096, 4096, -4096, 4096));
		send_item(box_item(15, -4096, 4096, -4096, 4096, -4096, 4096));
		// nearest point exactly on the ball surface, then just outside
		send_item(box_item(0, 8192, 9000, -1, 1, -1, 1));
		send_item(box_item(0, 8193, 9000, -1, 1, -1, 1));
		send_item(box_item(3, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
		send_item(box_item(2, 4096, -4096, 4096, -4096, 4096, -4096));
	endtask

	// Fill the whole table, then enable it, including an oversized count
	task automatic test_shell_table();
		send_item(shell_item(0, 0, 0, 0));
		send_item(shell_item(1, RAD_MAX, RAD_MAX, 15));
		send_item(shell_item(2, 40960, 20480, 5));
		send_item(shell_item(3, 0, RAD_MAX, LVL_NONE));
		send_item(shell_item(4, 16384, 32768, 7));
		send_item(shell_item(5, 65536, 131072, -16));
		send_item(shell_item(6, 12288, 12288, 9));
		send_item(shell_item(7, 1 << 20, 1 << 21, 12));
		settle();
		write_reg(REG_SHELL_COUNT, 24'd8);
		send_item(box_item(4, -1, 1, -1, 1, -1, 1));
		send_item(box_item(7, 14000, 20000, -10, 10, -10, 10));
		send_item(box_item(12, 1500000, 1600000, 0, 0, 0, 0));
		send_item(box_item(9, 12288, 12288, 0, 0, 0, 0));
		settle();
		write_reg(REG_SHELL_COUNT, 24'hFFFFFF);
		send_item(box_item(15, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
		send_item(box_item(0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
	endtask

	// Register extremes and the two unmapped indexes
	task automatic test_register_extremes();
		settle();
		write_reg(REG_CENTER_X, COORD_MIN[COORD_W-1:0]);
		write_reg(REG_CENTER_Y, COORD_MAX[COORD_W-1:0]);
		write_reg(REG_CENTER_Z, '0);
		write_reg(REG_FILLED_RADIUS, RAD_MAX[COORD_W-1:0]);
		write_reg(REG_FILLED_LEVEL, 24'd15);
		write_reg(REG_SHELL_COUNT, 24'd0);
		write_reg(REG_UNMAPPED_6, COORD_W'($urandom));
		write_reg(REG_UNMAPPED_7, COORD_W'($urandom));
		send_item(box_item(15, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX));
		send_item(box_item(5, COORD_MIN, COORD_MIN + 4096, COORD_MAX - 4096, COORD_MAX, 0, 0));
		settle();
		write_reg(REG_FILLED_RADIUS, '0);
		write_reg(REG_FILLED_LEVEL, 24'h1F);
		write_reg(REG_SHELL_COUNT, 24'd3);
		send_item(box_item(0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 0, 0));
		send_item(box_item(0, COORD_MIN + 1, COORD_MIN + 8, COORD_MAX, COORD_MAX, -5, 5));
	endtask

	// Random settings for one phase of traffic
	task automatic randomize_settings();
		logic [COORD_W-1:0] c;
		int k;
		settle();
		for (k = 0; k < 3; k++) begin
			if ($urandom_range(0, 7) == 0)
				c = COORD_W'($urandom);
			else
				c = COORD_W'(longint'($urandom_range(0, 1 << 21)) - (1 << 20));
			write_reg(REG_CENTER_X + k[2:0], c);
		end
		if ($urandom_range(0, 7) == 0)
			write_reg(REG_FILLED_RADIUS, COORD_W'($urandom));
		else
			write_reg(REG_FILLED_RADIUS, COORD_W'($urandom_range(0, 1 << $urandom_range(8, 21))));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_FILLED_LEVEL, COORD_W'($urandom));
		else
			write_reg(REG_FILLED_LEVEL, COORD_W'($urandom_range(0, 16) - 1));
		if ($urandom_range(0, 3) == 0)
			write_reg(REG_SHELL_COUNT, COORD_W'($urandom));
		else
			write_reg(REG_SHELL_COUNT, COORD_W'($urandom_range(0, TABLE_DEPTH)));
		if ($urandom_range(0, 3) == 0)
			write_reg($urandom_range(0, 1) ? REG_UNMAPPED_6 : REG_UNMAPPED_7, COORD_W'($urandom));
		n_settings++;
	endtask

	// Mixed loads and classifies under random idling on both sides
	task automatic test_random_traffic();
		int ph, n;
		for (ph = 0; ph < 6; ph++) begin
			randomize_settings();
			gap_odds = 3 * $urandom_range(0, 2);
			stall_odds = 3 * $urandom_range(0, 2);
			for (n = 0; n < 100; n++) begin
				// one pause mid-phase with everything drained
				if (ph == 2 && n == 50)
					settle();
				if ($urandom_range(0, 3) == 0)
					send_item(make_shell());
				else
					send_item(make_box());
			end
		end
	endtask

	// Back-to-back traffic with no idling at all
	task automatic test_steady_stream();
		int n;
		randomize_settings();
		gap_odds = 0;
		stall_odds = 0;
		for (n = 0; n < 125; n++) begin
			if ($urandom_range(0, 4) == 0)
				send_item(make_shell());
			else
				send_item(make_box());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		op <= OP_LOAD;
		shell_index <= '0;
		shell_inner <= '0;
		shell_outer <= '0;
		shell_level <= '0;
		block_level <= '0;
		x_min <= '0;
		x_max <= '0;
		y_min <= '0;
		y_max <= '0;
		z_min <= '0;
		z_max <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_CENTER_X;
		cfg_data <= '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_shell_table();
		test_register_extremes();
		test_random_traffic();
		test_steady_stream();

		settle();
		$display("Checked %0d classify results with %0d shell loads in between,", n_classified,
			n_loads);
		$display("over %0d register writes and %0d random settings.", n_writes, n_settings);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
